@@ design/cau_pkg.sv @@
// Shared types and constants for the complex arithmetic unit.
// No dependencies; every module of the unit imports this package.
package cau_pkg;

   localparam int DATA_WIDTH      = 16;
   localparam int FRAC_BITS_DEF   = 8;
   localparam int QUEUE_DEPTH_DEF = 4;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]                   op;
      logic signed [DATA_WIDTH-1:0] a_real;
      logic signed [DATA_WIDTH-1:0] a_imag;
      logic signed [DATA_WIDTH-1:0] b_real;
      logic signed [DATA_WIDTH-1:0] b_imag;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] result_real;
      logic signed [DATA_WIDTH-1:0] result_imag;
      logic                         saturated;
      logic                         divide_by_zero;
   } rsp_type;

   // Classified word handed from the front end to the back end.
   typedef struct packed {
      op_type                       op;
      logic                         dbz;
      logic signed [DATA_WIDTH-1:0] a_real;
      logic signed [DATA_WIDTH-1:0] a_imag;
      logic signed [DATA_WIDTH-1:0] b_real;
      logic signed [DATA_WIDTH-1:0] b_imag;
   } cls_type;

endpackage

@@ design/cau_front.sv @@
// Front end: decodes the op of each request word and flags a zero divisor.
// Depends on cau_pkg.
module cau_front
   import cau_pkg::*;
(
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    push_valid,
   input  logic    push_ready,
   output cls_type push_data
);

   logic b_zero;

   assign b_zero = (req_data.b_real == '0) && (req_data.b_imag == '0);

   always_comb begin
      push_data.op     = op_type'(req_data.op);
      push_data.dbz    = (op_type'(req_data.op) == OP_DIV) && b_zero;
      push_data.a_real = req_data.a_real;
      push_data.a_imag = req_data.a_imag;
      push_data.b_real = req_data.b_real;
      push_data.b_imag = req_data.b_imag;
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule

@@ design/cau_queue.sv @@
// Short queue of classified words between front and back end.
// Depends on cau_pkg.
module cau_queue
   import cau_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cls_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cls_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cls_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               push, pop;

   assign push_ready = (cnt_ff != CNT_W'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ design/cau_back.sv @@
// Back end: add/sub, multiply, combine, pipelined restoring divide, truncate and clamp.
// Depends on cau_pkg.
module cau_back
   import cau_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cls_type in_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int W  = DATA_WIDTH;
   localparam int PW = 2 * W;
   localparam int MW = 2 * W + 1;
   localparam int QW = W + 2;
   localparam int RW = MW + QW + 1;

   typedef struct packed {
      logic              vld;
      op_type            op;
      logic              dbz;
      logic signed [PW-1:0] rr, ii, ri, ir, brr, bii;
      logic signed [W:0]    sre, sim;
   } s1_type;

   typedef struct packed {
      logic          vld;
      logic          div;
      logic          dbz;
      logic          re_neg, im_neg;
      logic [MW-1:0] re_mag, im_mag, den;
   } s2_type;

   typedef struct packed {
      logic          vld;
      logic          div;
      logic          dbz;
      logic          re_neg, im_neg;
      logic          re_ovf, im_ovf;
      logic [MW-1:0] den;
      logic [RW-1:0] re_rem, im_rem;
      logic [QW-1:0] re_q, im_q;
   } dv_type;

   function automatic logic [W:0] clamp_part(input logic neg, input logic [MW-1:0] mag);
      logic [MW-1:0] half;
      logic [MW-1:0] m;
      logic          sat;
      half = MW'(1) << (W - 1);
      m    = mag;
      sat  = 1'b0;
      if (!neg) begin
         if (m > half - 1'b1) begin
            m   = half - 1'b1;
            sat = 1'b1;
         end
         return {sat, m[W-1:0]};
      end
      if (m > half) begin
         m   = half;
         sat = 1'b1;
      end
      m = ~m + 1'b1;
      return {sat, m[W-1:0]};
   endfunction

   logic    adv;
   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   dv_type  dv_ff [QW+1];
   dv_type  dv_in [QW+1];
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff;

   // Whole pipeline moves together; the queue ahead absorbs a stall.
   assign adv      = !rsp_valid_ff || rsp_ready;
   assign in_ready = adv;

   // Stage 1: all products and the add/sub sums.
   always_comb begin
      s1_in.vld = in_valid;
      s1_in.op  = in_data.op;
      s1_in.dbz = in_data.dbz;
      s1_in.rr  = in_data.a_real * in_data.b_real;
      s1_in.ii  = in_data.a_imag * in_data.b_imag;
      s1_in.ri  = in_data.a_real * in_data.b_imag;
      s1_in.ir  = in_data.a_imag * in_data.b_real;
      s1_in.brr = in_data.b_real * in_data.b_real;
      s1_in.bii = in_data.b_imag * in_data.b_imag;
      if (in_data.op == OP_SUB) begin
         s1_in.sre = (W+1)'(in_data.a_real) - (W+1)'(in_data.b_real);
         s1_in.sim = (W+1)'(in_data.a_imag) - (W+1)'(in_data.b_imag);
      end else begin
         s1_in.sre = (W+1)'(in_data.a_real) + (W+1)'(in_data.b_real);
         s1_in.sim = (W+1)'(in_data.a_imag) + (W+1)'(in_data.b_imag);
      end
   end

   // Stage 2: combine products, split into sign and magnitude.
   logic signed [MW:0] re_s, im_s;
   logic [MW-1:0]      re_m, im_m;

   always_comb begin
      unique case (s1_ff.op)
         OP_MUL: begin
            re_s = (MW+1)'(s1_ff.rr) - (MW+1)'(s1_ff.ii);
            im_s = (MW+1)'(s1_ff.ri) + (MW+1)'(s1_ff.ir);
         end
         OP_DIV: begin
            re_s = (MW+1)'(s1_ff.rr) + (MW+1)'(s1_ff.ii);
            im_s = (MW+1)'(s1_ff.ir) - (MW+1)'(s1_ff.ri);
         end
         default: begin
            re_s = (MW+1)'(s1_ff.sre);
            im_s = (MW+1)'(s1_ff.sim);
         end
      endcase
      re_m = re_s[MW] ? MW'(-re_s) : MW'(re_s);
      im_m = im_s[MW] ? MW'(-im_s) : MW'(im_s);
      s2_in.vld    = s1_ff.vld;
      // a zero divisor bypasses the divider; both numerators are zero then
      s2_in.div    = (s1_ff.op == OP_DIV) && !s1_ff.dbz;
      s2_in.dbz    = s1_ff.dbz;
      s2_in.re_neg = re_s[MW];
      s2_in.im_neg = im_s[MW];
      // truncate toward zero on the magnitude
      s2_in.re_mag = (s1_ff.op == OP_MUL) ? (re_m >> FRAC_BITS) : re_m;
      s2_in.im_mag = (s1_ff.op == OP_MUL) ? (im_m >> FRAC_BITS) : im_m;
      s2_in.den    = MW'($unsigned(s1_ff.brr)) + MW'($unsigned(s1_ff.bii));
   end

   // Stage 3: scale numerators, flag quotients too large for QW bits.
   logic [RW-1:0] re_num, im_num, den_top;

   always_comb begin
      re_num  = RW'(s2_ff.re_mag) << FRAC_BITS;
      im_num  = RW'(s2_ff.im_mag) << FRAC_BITS;
      den_top = RW'(s2_ff.den) << QW;
      dv_in[0].vld    = s2_ff.vld;
      dv_in[0].div    = s2_ff.div;
      dv_in[0].dbz    = s2_ff.dbz;
      dv_in[0].re_neg = s2_ff.re_neg;
      dv_in[0].im_neg = s2_ff.im_neg;
      dv_in[0].re_ovf = s2_ff.div && !s2_ff.dbz && (re_num >= den_top);
      dv_in[0].im_ovf = s2_ff.div && !s2_ff.dbz && (im_num >= den_top);
      dv_in[0].den    = s2_ff.den;
      dv_in[0].re_rem = s2_ff.div ? re_num : RW'(s2_ff.re_mag);
      dv_in[0].im_rem = s2_ff.div ? im_num : RW'(s2_ff.im_mag);
      dv_in[0].re_q   = '0;
      dv_in[0].im_q   = '0;
   end

   // Divide stages: one quotient bit per stage, most significant first.
   for (genvar j = 0; j < QW; j++) begin : g_div
      localparam int K = QW - 1 - j;
      logic [RW-1:0] dsh;
      always_comb begin
         dsh = RW'(dv_ff[j].den) << K;
         dv_in[j+1] = dv_ff[j];
         if (dv_ff[j].div && !dv_ff[j].re_ovf && (dv_ff[j].re_rem >= dsh)) begin
            dv_in[j+1].re_rem  = dv_ff[j].re_rem - dsh;
            dv_in[j+1].re_q[K] = 1'b1;
         end
         if (dv_ff[j].div && !dv_ff[j].im_ovf && (dv_ff[j].im_rem >= dsh)) begin
            dv_in[j+1].im_rem  = dv_ff[j].im_rem - dsh;
            dv_in[j+1].im_q[K] = 1'b1;
         end
      end
   end

   // Output stage: pick the magnitude and clamp each part.
   logic [MW-1:0] re_fin, im_fin;
   logic [W:0]    re_cl, im_cl;

   always_comb begin
      if (dv_ff[QW].div) begin
         re_fin = dv_ff[QW].re_ovf ? {MW{1'b1}} : MW'(dv_ff[QW].re_q);
         im_fin = dv_ff[QW].im_ovf ? {MW{1'b1}} : MW'(dv_ff[QW].im_q);
      end else begin
         re_fin = dv_ff[QW].re_rem[MW-1:0];
         im_fin = dv_ff[QW].im_rem[MW-1:0];
      end
      re_cl = clamp_part(dv_ff[QW].re_neg, re_fin);
      im_cl = clamp_part(dv_ff[QW].im_neg, im_fin);
      rsp_in.result_real    = re_cl[W-1:0];
      rsp_in.result_imag    = im_cl[W-1:0];
      rsp_in.saturated      = re_cl[W] || im_cl[W];
      rsp_in.divide_by_zero = dv_ff[QW].dbz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.vld    <= 1'b0;
         s2_ff.vld    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i <= QW; i++) begin
            dv_ff[i].vld <= 1'b0;
         end
      end else if (adv) begin
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         rsp_valid_ff <= dv_ff[QW].vld;
         for (int i = 0; i <= QW; i++) begin
            dv_ff[i] <= dv_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_dbz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.divide_by_zero |->
         rsp_ff.result_real == '0 && rsp_ff.result_imag == '0 && !rsp_ff.saturated)
      else $error("divide by zero result not cleared");

   a_sat_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.saturated |->
         rsp_ff.result_real == {1'b0, {(W-1){1'b1}}} ||
         rsp_ff.result_real == {1'b1, {(W-1){1'b0}}} ||
         rsp_ff.result_imag == {1'b0, {(W-1){1'b1}}} ||
         rsp_ff.result_imag == {1'b1, {(W-1){1'b0}}})
      else $error("saturated flag without a clamped part");

   a_out_src: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff ##1 rsp_valid_ff |-> $past(dv_ff[QW].vld))
      else $error("result word without a source in the pipeline");

endmodule

@@ design/complex_arithmetic_unit_core.sv @@
// Complex add/sub/mul/div on signed Q8.8 operands, one result word per request word.
// Throughput: one word per cycle for every op unless rsp_ready stalls; the divider is fully pipelined.
// Stages from acceptance to rsp_valid: queue, product, combine, range check,
// one stage per quotient bit, clamp.
// Reset (synchronous, active high) empties the queue and clears all stage valids.
// Depends on cau_pkg, cau_front, cau_queue and cau_back.
module complex_arithmetic_unit_core
   import cau_pkg::*;
#(
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // front end to queue
   logic    push_valid, push_ready;
   cls_type push_data;
   // queue to back end
   logic    pop_valid, pop_ready;
   cls_type pop_data;

   // Classify each word: decode op, flag a zero divisor.
   cau_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // Hold classified words while the back end stalls on the result side.
   cau_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Compute, divide, truncate and clamp; the output register parts the result side.
   cau_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pop_valid),
      .in_ready  (pop_ready),
      .in_data   (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
